@@ sv/dvc_pkg.sv @@
// shared types and constants of the distinct value counter
package dvc_pkg;

  localparam int VALUE_W      = 32;
  localparam int COUNT_W      = 5;
  localparam int INDEX_W      = 4;
  localparam int RESULT_LIMIT = 16;

  typedef enum logic [2:0] {
    S_LOAD,
    S_PIVOT,
    S_SCAN,
    S_TAIL,
    S_DECIDE,
    S_FLUSH
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic wr_en;
    logic rd_en;
    logic pivot_ld;
    logic cmp_en;
    logic decide;
    logic flush;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic               seen;
    logic               out_free;
    logic               pend_v;
    logic [COUNT_W-1:0] emit_cnt;
  } status_t;

endpackage

@@ sv/dvc_ram.sv @@
// generic single-port-write, single-port-read ram with registered read
module dvc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic                                     re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ sv/dvc_ctrl.sv @@
// sequencer for loading a set and running the pairwise compare pass
module dvc_ctrl #(
  parameter int SET_SIZE = 16,
  localparam int IW = (SET_SIZE > 1) ? $clog2(SET_SIZE) : 1
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  dvc_pkg::status_t sts,
  output dvc_pkg::cmd_t    cmd,
  output logic [IW-1:0]    wr_addr,
  output logic [IW-1:0]    rd_addr,
  output logic [IW-1:0]    cmp_idx,
  output logic [IW-1:0]    pos
);

  localparam logic [IW-1:0] LAST_IDX = IW'(SET_SIZE - 1);

  dvc_pkg::state_t state_r, state_nxt;
  logic [IW-1:0] load_cnt_r, pos_r, k_r, cmp_idx_r;
  logic          cmp_v_r, scan_first_r;
  logic          can_decide, stop;

  // a new distinct value needs a free output slot only when one is pending
  assign can_decide = sts.seen || !sts.pend_v || sts.out_free;
  assign stop = (pos_r == LAST_IDX) ||
                (!sts.seen && (sts.emit_cnt == dvc_pkg::COUNT_W'(dvc_pkg::RESULT_LIMIT - 1)));

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      dvc_pkg::S_LOAD: begin
        if (in_valid && (load_cnt_r == LAST_IDX)) state_nxt = dvc_pkg::S_PIVOT;
      end
      dvc_pkg::S_PIVOT:  state_nxt = dvc_pkg::S_SCAN;
      dvc_pkg::S_SCAN: begin
        if (k_r == LAST_IDX) state_nxt = dvc_pkg::S_TAIL;
      end
      dvc_pkg::S_TAIL:   state_nxt = dvc_pkg::S_DECIDE;
      dvc_pkg::S_DECIDE: begin
        if (can_decide) state_nxt = stop ? dvc_pkg::S_FLUSH : dvc_pkg::S_PIVOT;
      end
      dvc_pkg::S_FLUSH: begin
        if (sts.out_free) state_nxt = dvc_pkg::S_LOAD;
      end
      default: state_nxt = dvc_pkg::S_LOAD;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    rd_addr  = k_r;
    unique case (state_r)
      dvc_pkg::S_LOAD: begin
        in_stall   = 1'b0;
        cmd.wr_en  = in_valid;
      end
      dvc_pkg::S_PIVOT: begin
        cmd.rd_en = 1'b1;
        rd_addr   = pos_r;
      end
      dvc_pkg::S_SCAN: begin
        cmd.rd_en    = 1'b1;
        cmd.pivot_ld = scan_first_r;
        cmd.cmp_en   = cmp_v_r;
      end
      dvc_pkg::S_TAIL:   cmd.cmp_en = cmp_v_r;
      dvc_pkg::S_DECIDE: cmd.decide = can_decide;
      dvc_pkg::S_FLUSH:  cmd.flush  = sts.out_free;
      default: ;
    endcase
  end

  assign wr_addr = load_cnt_r;
  assign cmp_idx = cmp_idx_r;
  assign pos     = pos_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= dvc_pkg::S_LOAD;
      load_cnt_r   <= '0;
      pos_r        <= '0;
      k_r          <= '0;
      cmp_idx_r    <= '0;
      cmp_v_r      <= 1'b0;
      scan_first_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      cmp_v_r      <= (state_r == dvc_pkg::S_SCAN);
      cmp_idx_r    <= k_r;
      scan_first_r <= (state_r == dvc_pkg::S_PIVOT);
      if (state_r == dvc_pkg::S_LOAD && in_valid) begin
        load_cnt_r <= (load_cnt_r == LAST_IDX) ? '0 : load_cnt_r + 1'b1;
        pos_r      <= '0;
      end
      if (state_r == dvc_pkg::S_PIVOT) k_r <= '0;
      if (state_r == dvc_pkg::S_SCAN && k_r != LAST_IDX) k_r <= k_r + 1'b1;
      if (state_r == dvc_pkg::S_DECIDE && can_decide && !stop) pos_r <= pos_r + 1'b1;
    end
  end

endmodule

@@ sv/dvc_dpath.sv @@
// element store, compare accumulators, pending result and output register
module dvc_dpath #(
  parameter int SET_SIZE = 16,
  localparam int IW = (SET_SIZE > 1) ? $clog2(SET_SIZE) : 1
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  dvc_pkg::cmd_t                       cmd,
  input  logic [IW-1:0]                       wr_addr,
  input  logic [IW-1:0]                       rd_addr,
  input  logic [IW-1:0]                       cmp_idx,
  input  logic [IW-1:0]                       pos,
  output dvc_pkg::status_t                    sts,
  input  logic signed [dvc_pkg::VALUE_W-1:0]  in_element_value,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [dvc_pkg::VALUE_W-1:0]  out_distinct_value,
  output logic [dvc_pkg::COUNT_W-1:0]         out_occurrence_count,
  output logic [dvc_pkg::INDEX_W-1:0]         out_distinct_index,
  output logic                                out_last_of_run
);

  logic [dvc_pkg::VALUE_W-1:0] rdata, pivot_r, pend_val_r, out_val_r;
  logic [dvc_pkg::COUNT_W-1:0] cnt_r, pend_cnt_r, emit_r, out_cnt_r;
  logic [dvc_pkg::INDEX_W-1:0] pend_idx_r, out_idx_r;
  logic                        seen_r, pend_v_r, out_v_r, out_last_r, eq, out_free;

  dvc_ram #(.WIDTH(dvc_pkg::VALUE_W), .DEPTH(SET_SIZE)) u_store (
    .clk   (clk),
    .we    (cmd.wr_en),
    .waddr (wr_addr),
    .wdata (in_element_value),
    .re    (cmd.rd_en),
    .raddr (rd_addr),
    .rdata (rdata)
  );

  assign eq       = (rdata == pivot_r);
  assign out_free = !out_v_r || !out_stall;

  assign sts.seen     = seen_r;
  assign sts.out_free = out_free;
  assign sts.pend_v   = pend_v_r;
  assign sts.emit_cnt = emit_r;

  always_ff @(posedge clk) begin
    if (cmd.pivot_ld) begin
      pivot_r <= rdata;
      seen_r  <= 1'b0;
      cnt_r   <= '0;
    end else if (cmd.cmp_en && eq) begin
      // earlier copies mark it as seen, later copies (and itself) are counted
      if (cmp_idx < pos) seen_r <= 1'b1;
      else               cnt_r  <= cnt_r + 1'b1;
    end
    if (cmd.decide && !seen_r) begin
      pend_val_r <= pivot_r;
      pend_cnt_r <= cnt_r;
      pend_idx_r <= emit_r[dvc_pkg::INDEX_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_v_r <= 1'b0;
      emit_r   <= '0;
      out_v_r  <= 1'b0;
    end else begin
      if ((cmd.decide && !seen_r && pend_v_r) || cmd.flush) begin
        out_v_r <= 1'b1;
      end else if (!out_stall) begin
        out_v_r <= 1'b0;
      end
      if (cmd.decide && !seen_r) begin
        pend_v_r <= 1'b1;
        emit_r   <= emit_r + 1'b1;
      end else if (cmd.flush) begin
        pend_v_r <= 1'b0;
        emit_r   <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if ((cmd.decide && !seen_r && pend_v_r) || cmd.flush) begin
      out_val_r  <= pend_val_r;
      out_cnt_r  <= pend_cnt_r;
      out_idx_r  <= pend_idx_r;
      out_last_r <= cmd.flush;
    end
  end

  assign out_valid            = out_v_r;
  assign out_distinct_value   = out_val_r;
  assign out_occurrence_count = out_cnt_r;
  assign out_distinct_index   = out_idx_r;
  assign out_last_of_run      = out_last_r;

endmodule

@@ sv/distinct_value_counts.sv @@
// top level of the distinct value counter
//
// The block takes SET_SIZE signed 32-bit values, one per input beat, into a
// small ram. After the last value of a set it makes one compare pass per
// stored position: the position's value is read as the pivot, then every
// stored entry is read once through the single read port and compared.
// Results come out one beat per distinct value in order of first
// appearance, with value, occurrence count (wrapping at 5 bits), index and
// a last-of-run flag; at most 16 results per set, the pass stops at the
// sixteenth distinct value. Each result is held one step back until the
// next distinct value (or the end of the pass) tells whether it is the
// last. No input is taken during the compare pass; loading of the next set
// starts while the final result beat may still be waiting downstream.
module distinct_value_counts #(
  parameter int SET_SIZE = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // input channel
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [dvc_pkg::VALUE_W-1:0]  in_element_value,
  // result channel
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [dvc_pkg::VALUE_W-1:0]  out_distinct_value,
  output logic [dvc_pkg::COUNT_W-1:0]         out_occurrence_count,
  output logic [dvc_pkg::INDEX_W-1:0]         out_distinct_index,
  output logic                                out_last_of_run
);

  localparam int IW = (SET_SIZE > 1) ? $clog2(SET_SIZE) : 1;

  dvc_pkg::cmd_t    cmd;
  dvc_pkg::status_t sts;
  logic [IW-1:0]    wr_addr, rd_addr, cmp_idx, pos;

  // sequencer: load counter, pivot position and scan index
  dvc_ctrl #(.SET_SIZE(SET_SIZE)) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd),
    .wr_addr  (wr_addr),
    .rd_addr  (rd_addr),
    .cmp_idx  (cmp_idx),
    .pos      (pos)
  );

  // element store, comparator, pending result and output register
  dvc_dpath #(.SET_SIZE(SET_SIZE)) u_dpath (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cmd                  (cmd),
    .wr_addr              (wr_addr),
    .rd_addr              (rd_addr),
    .cmp_idx              (cmp_idx),
    .pos                  (pos),
    .sts                  (sts),
    .in_element_value     (in_element_value),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_distinct_value   (out_distinct_value),
    .out_occurrence_count (out_occurrence_count),
    .out_distinct_index   (out_distinct_index),
    .out_last_of_run      (out_last_of_run)
  );

endmodule

@@ sim/distinct_value_counts_chk.sv @@
// checker for the distinct value counter: predicts the result beats of each set and compares them
module distinct_value_counts_chk #(
  parameter int SET_SIZE = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  input  logic                                in_stall,
  input  logic signed [dvc_pkg::VALUE_W-1:0]  in_element_value,
  input  logic                                out_valid,
  input  logic                                out_stall,
  input  logic signed [dvc_pkg::VALUE_W-1:0]  out_distinct_value,
  input  logic [dvc_pkg::COUNT_W-1:0]         out_occurrence_count,
  input  logic [dvc_pkg::INDEX_W-1:0]         out_distinct_index,
  input  logic                                out_last_of_run,
  output int                                  fail_count,
  output int                                  tallies_pending,
  output int                                  sets_done,
  output int                                  results_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [dvc_pkg::VALUE_W-1:0] value;
    logic [dvc_pkg::COUNT_W-1:0] count;
    logic [dvc_pkg::INDEX_W-1:0] index;
    logic                        last;
  } tally_t;

  tally_t                      tally_q[$];
  logic [dvc_pkg::VALUE_W-1:0] set_store[SET_SIZE];
  int                          fill;

  // one tally per distinct value, first appearance order, capped at the result limit
  function automatic void tally_set();
    tally_t      found[dvc_pkg::RESULT_LIMIT];
    tally_t      t;
    int unsigned emitted;
    int unsigned hits;
    int          pos;
    int          k;
    bit          dup;
    emitted = 0;
    for (pos = 0; pos < SET_SIZE; pos++) begin
      if (emitted < dvc_pkg::RESULT_LIMIT) begin
        dup = 1'b0;
        for (k = 0; k < pos; k++)
          if (set_store[k] == set_store[pos]) dup = 1'b1;
        if (!dup) begin
          hits = 0;
          for (k = pos; k < SET_SIZE; k++)
            if (set_store[k] == set_store[pos]) hits++;
          t.value = set_store[pos];
          t.count = hits[dvc_pkg::COUNT_W-1:0];
          t.index = emitted[dvc_pkg::INDEX_W-1:0];
          t.last  = 1'b0;
          found[emitted] = t;
          emitted++;
        end
      end
    end
    for (k = 0; k < emitted; k++) begin
      t = found[k];
      t.last = (k == emitted - 1);
      tally_q.push_back(t);
    end
  endfunction

  function automatic void check_beat();
    tally_t t;
    results_seen++;
    if (tally_q.size() == 0) begin
      $error("result beat with nothing pending: distinct_value %0d", out_distinct_value);
      fail_count++;
    end else begin
      t = tally_q.pop_front();
      if (out_distinct_value !== t.value) begin
        $error("distinct_value: expected %0d, got %0d", $signed(t.value), out_distinct_value);
        fail_count++;
      end
      if (out_occurrence_count !== t.count) begin
        $error("occurrence_count: expected %0d, got %0d", t.count, out_occurrence_count);
        fail_count++;
      end
      if (out_distinct_index !== t.index) begin
        $error("distinct_index: expected %0d, got %0d", t.index, out_distinct_index);
        fail_count++;
      end
      if (out_last_of_run !== t.last) begin
        $error("last_of_run: expected %0d, got %0d", t.last, out_last_of_run);
        fail_count++;
      end
    end
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      tally_q.delete();
      fill         = 0;
      fail_count   = 0;
      sets_done    = 0;
      results_seen = 0;
    end else begin
      // results first: a beat leaving now always belongs to an earlier set
      if (out_valid && !out_stall) check_beat();
      if (in_valid && !in_stall) begin
        set_store[fill] = in_element_value;
        fill++;
        if (fill == SET_SIZE) begin
          fill = 0;
          tally_set();
          sets_done++;
        end
      end
    end
    tallies_pending = tally_q.size();
  end

endmodule

@@ sim/distinct_value_counts_tb.sv @@
// testbench top for the distinct value counter: stimulus, idle phases, hold-off and verdict
module distinct_value_counts_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SET_SIZE        = 16;
  // 1 directed set plus these gives 288 input beats
  localparam int RANDOM_SETS     = 17;
  localparam int HOLD_OFF_CYCLES = 400;

  localparam logic [dvc_pkg::VALUE_W-1:0] MOST_NEG = 32'h8000_0000;
  localparam logic [dvc_pkg::VALUE_W-1:0] MOST_POS = 32'h7fff_ffff;
  localparam logic [dvc_pkg::VALUE_W-1:0] ALL_ONES = 32'hffff_ffff;

  // shapes of a generated set
  typedef enum int {
    SET_SPREAD,  // all random, practically all distinct: sixteen results
    SET_FEW,     // two to four candidate values, many repeats
    SET_SAME,    // one value repeated over the whole set
    SET_MIXED    // five to sixteen candidate values, uneven counts
  } set_kind_t;

  logic                                clk;
  logic                                rst_n;
  logic                                in_valid;
  logic                                in_stall;
  logic signed [dvc_pkg::VALUE_W-1:0]  in_element_value;
  logic                                out_valid;
  logic                                out_stall;
  logic signed [dvc_pkg::VALUE_W-1:0]  out_distinct_value;
  logic [dvc_pkg::COUNT_W-1:0]         out_occurrence_count;
  logic [dvc_pkg::INDEX_W-1:0]         out_distinct_index;
  logic                                out_last_of_run;

  // knobs for the sender and receiver processes
  int send_idle_pct;
  int stall_pct;
  int hold_off_left;

  // from the checker
  int fail_count;
  int tallies_pending;
  int sets_done;
  int results_seen;

  distinct_value_counts #(
    .SET_SIZE(SET_SIZE)
  ) dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_element_value     (in_element_value),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_distinct_value   (out_distinct_value),
    .out_occurrence_count (out_occurrence_count),
    .out_distinct_index   (out_distinct_index),
    .out_last_of_run      (out_last_of_run)
  );

  distinct_value_counts_chk #(
    .SET_SIZE(SET_SIZE)
  ) tally_chk (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_element_value     (in_element_value),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_distinct_value   (out_distinct_value),
    .out_occurrence_count (out_occurrence_count),
    .out_distinct_index   (out_distinct_index),
    .out_last_of_run      (out_last_of_run),
    .fail_count           (fail_count),
    .tallies_pending      (tallies_pending),
    .sets_done            (sets_done),
    .results_seen         (results_seen)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // hard stop, far beyond the slowest correct run
  initial begin
    #2_000_000;
    $display("** distinct_value_counts: FAILED **");
    $finish;
  end

  // receiver: random stall per cycle, or a counted hold-off when one is requested
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_left > 0) begin
        out_stall <= 1'b1;
        hold_off_left--;
      end else begin
        out_stall <= ($urandom_range(99) < stall_pct);
      end
    end
  end

  // edge values show up often so the sign bit and all-ones patterns get exercised
  function automatic logic [dvc_pkg::VALUE_W-1:0] pick_value();
    case ($urandom_range(7))
      0:       return MOST_NEG;
      1:       return MOST_POS;
      2:       return '0;
      3:       return ALL_ONES;
      4:       return 32'd1;
      default: return $urandom;
    endcase
  endfunction

  // one beat on the input channel; called just after a falling edge, returns just after one
  task automatic send_value(input logic [dvc_pkg::VALUE_W-1:0] v);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid         <= 1'b0;
      in_element_value <= $urandom;
      @(negedge clk);
    end
    in_valid         <= 1'b1;
    in_element_value <= v;
    // payload holds until the beat is taken
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic run_set(input set_kind_t kind);
    logic [dvc_pkg::VALUE_W-1:0] pool[SET_SIZE];
    int                          pool_n;
    int                          i;
    case (kind)
      SET_SAME:  pool_n = 1;
      SET_FEW:   pool_n = $urandom_range(4, 2);
      SET_MIXED: pool_n = $urandom_range(SET_SIZE, 5);
      default:   pool_n = SET_SIZE;
    endcase
    for (i = 0; i < SET_SIZE; i++)
      pool[i] = (kind == SET_SPREAD) ? $urandom : pick_value();
    for (i = 0; i < SET_SIZE; i++) begin
      if (kind == SET_SPREAD) send_value(pool[i]);
      else send_value(pool[$urandom_range(pool_n - 1)]);
    end
  endtask

  initial begin : stimulus
    int i;
    int s;
    rst_n            = 1'b0;
    in_valid         = 1'b0;
    in_element_value = '0;
    send_idle_pct    = 0;
    stall_pct        = 0;
    hold_off_left    = 0;
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;

    // directed: every value the most negative one, so a single result with
    // a full count and the last-of-run mark; each partial load gives nothing
    for (i = 0; i < SET_SIZE; i++) send_value(MOST_NEG);

    // random sets; the first four walk through every set shape
    for (s = 0; s < RANDOM_SETS; s++) begin
      case (s)
        0:  begin send_idle_pct = 0;  stall_pct = 0;  end  // back to back
        5:  begin send_idle_pct = 85; stall_pct = 0;  end  // sparse sender
        9:  begin send_idle_pct = 0;  stall_pct = 85; end  // slow receiver
        13: begin send_idle_pct = 29; stall_pct = 29; end  // both sides idle
        default: ;
      endcase
      // long receiver hold-off while beats keep coming, so the compare pass
      // backs up and the input channel stalls
      if (s == 3) hold_off_left = HOLD_OFF_CYCLES;
      if (s < 4) run_set(set_kind_t'(s));
      else run_set(set_kind_t'($urandom_range(3)));
    end
    in_valid  <= 1'b0;
    stall_pct  = 0;

    // drain every pending result, then a margin to catch stray beats
    while (tallies_pending != 0) @(posedge clk);
    repeat (4 * SET_SIZE) @(posedge clk);

    $display("run covered %0d sets of %0d values and checked %0d result beats",
             sets_done, SET_SIZE, results_seen);
    $display("with no idling, sparse sender, slow receiver, both idle, and a %0d cycle hold-off",
             HOLD_OFF_CYCLES);
    if (fail_count == 0 && tallies_pending == 0) begin
      $display("** distinct_value_counts: PASSED **");
    end else begin
      $display("** distinct_value_counts: FAILED **");
    end
    $finish;
  end

endmodule
